/* sv/rrc_pkg.sv */
`timescale 1ns / 1ps

package rrc_pkg;

    // Port field widths are fixed by the interface, independent of storage.
    localparam int KEY_W    = 64;
    localparam int VICTIM_W = 10;
    localparam int SIZE_W   = 11;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic [KEY_W-1:0]    access_key;
        logic [VICTIM_W-1:0] victim_slot;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic             bad_victim;
    } t_res;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;      // capture request, clear scan state
        logic scan;      // issue next read and compare last read data
        logic res_hit;   // record a hit result
        logic append;    // write key to the next free slot
        logic evict_rd;  // read the victim slot
        logic evict_wr;  // overwrite the victim slot, record the old key
        logic out_load;  // move the pending result to the output register
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic hit;       // a stored key matched
        logic scan_end;  // all held slots issued and compared
        logic has_room;  // fewer entries held than the effective size
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage

/* sv/rrc_ctrl.sv */
`timescale 1ns / 1ps

module rrc_ctrl import rrc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_idle
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SCAN     = 5'b00010,
        S_EVICT_RD = 5'b00100,
        S_EVICT_WR = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.hit) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.scan_end) begin
                    if (i_sts.has_room) begin
                        o_cmd.append = 1'b1;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_EVICT_RD;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_EVICT_RD: begin
                o_cmd.evict_rd = 1'b1;
                n_state        = S_EVICT_WR;
            end
            S_EVICT_WR: begin
                o_cmd.evict_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    a_evict_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVICT_RD |=> r_state == S_EVICT_WR)
        else $error("victim read not followed by victim write");

    a_done_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !i_sts.out_free |=> r_state == S_DONE)
        else $error("left done state without a free output register");

    a_load_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_SCAN)
        else $error("request load did not start a scan");

endmodule

/* sv/rrc_dpath.sv */
`timescale 1ns / 1ps

module rrc_dpath import rrc_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_out_stall,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_out_valid,
    output t_res              o_out_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam logic [31:0] CAP32 = 32'(CAPACITY);

    logic [KEY_WIDTH-1:0] r_mem [CAPACITY];

    logic [SIZE_W-1:0]    r_cache_size;
    logic [HW-1:0]        r_held;
    logic [KEY_WIDTH-1:0] r_key;
    logic [VICTIM_W-1:0]  r_victim;
    logic [HW-1:0]        r_addr;
    logic                 r_pend;
    logic                 r_hit;
    logic [KEY_WIDTH-1:0] r_rd_data;
    t_res                 r_res;
    t_res                 r_out;
    logic                 r_out_valid;

    logic [31:0]    eff_size;
    logic           bad_victim;
    logic [AW-1:0]  victim_idx;
    logic           issue;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           out_free;

    // Clamp the configured size into 1..CAPACITY.
    always_comb begin
        if (r_cache_size == '0) begin
            eff_size = 32'd1;
        end else if (32'(r_cache_size) > CAP32) begin
            eff_size = CAP32;
        end else begin
            eff_size = 32'(r_cache_size);
        end
    end

    assign bad_victim = (32'(r_victim) >= eff_size);
    assign victim_idx = bad_victim ? '0 : AW'(r_victim);

    assign issue   = i_cmd.scan && (r_addr < r_held);
    assign rd_en   = issue || i_cmd.evict_rd;
    assign rd_addr = i_cmd.evict_rd ? victim_idx : r_addr[AW-1:0];
    assign wr_en   = i_cmd.append || i_cmd.evict_wr;
    assign wr_addr = i_cmd.append ? r_held[AW-1:0] : victim_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_key;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Request capture and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_req.access_key[KEY_WIDTH-1:0];
            r_victim <= i_req.victim_slot;
        end
        if (i_cmd.res_hit) begin
            r_res     <= '0;
            r_res.hit <= 1'b1;
        end else if (i_cmd.append) begin
            r_res <= '0;
        end else if (i_cmd.evict_wr) begin
            r_res.hit         <= 1'b0;
            r_res.evicted     <= 1'b1;
            r_res.evicted_key <= KEY_W'(r_rd_data);
            r_res.bad_victim  <= bad_victim;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_size <= SIZE_RESET;
            r_held       <= '0;
            r_addr       <= '0;
            r_pend       <= 1'b0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cache_size <= i_cfg_data;
            end
            if (i_cmd.append) begin
                r_held <= HW'(r_held + 1'b1);
            end
            if (i_cmd.load) begin
                r_addr <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
            end else begin
                if (issue) begin
                    r_addr <= HW'(r_addr + 1'b1);
                end
                r_pend <= issue;
                if (i_cmd.scan && r_pend && (r_rd_data == r_key)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.hit      = r_hit;
    assign o_sts.scan_end = (r_addr == r_held) && !r_pend;
    assign o_sts.has_room = (32'(r_held) < eff_size);
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_held) <= CAP32)
        else $error("entry count above capacity");

    a_append_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |=> r_held == HW'($past(r_held) + 1'b1))
        else $error("append did not advance the entry count");

    a_pend_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(i_cmd.scan))
        else $error("compare pending without a scan read");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (32'(r_held) < eff_size) && !r_hit)
        else $error("append issued on a full cache or after a hit");

endmodule

/* sv/random_replacement_cache_core.sv */
`timescale 1ns / 1ps

// Fully associative key cache with externally chosen random replacement.
//
// Request channel (i_in_valid / o_in_stall / i_in_req): a key plus a victim
// slot. Result channel (o_out_valid / i_out_stall / o_out_res): one result
// per request carrying hit, evicted, evicted_key and bad_victim.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): cache_size; write
// it only while no request is in flight. The port is always ready.
//
// One request is processed at a time. The scan walks the held slots through
// the single key memory read port, one slot per cycle, so a miss reads every
// held slot before the append or the victim read and write, and an early hit
// ends it sooner; the scan stops as soon as a match is seen.
// Reset empties the cache (entry count to zero, no clearing pass of the key
// memory) and sets cache_size to 1024. A stalled result holds in the output
// register; the next request is taken while it waits, and its result holds
// in the core until the output register frees up.
module random_replacement_cache_core import rrc_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_req              i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_res              o_out_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    logic idle;

    rrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    rrc_dpath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

    // Take a new request only between requests.
    assign o_in_stall  = !idle;
    assign o_cfg_ready = 1'b1;

endmodule

/* dv/random_replacement_cache_core_tb.sv */
`timescale 1ns / 1ps

// Checks random_replacement_cache_core end to end: requests go in, each
// accepted request updates a local copy of the key store, and every result
// is compared field by field against the oldest predicted outcome.
module random_replacement_cache_core_tb;
    import rrc_pkg::*;

    localparam int CAPACITY       = 1024;
    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all
    localparam int END_TAIL       = 250;    // stray-result window at the end
    localparam int REPORT_MAX     = 10;
    localparam int POOL_MAX       = 96;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_req              in_req    = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [SIZE_W-1:0] cfg_data  = '0;
    logic              in_stall;
    logic              out_valid;
    t_res              out_res;
    logic              cfg_ready;

    random_replacement_cache_core #(
        .CAPACITY (CAPACITY),
        .KEY_WIDTH(KEY_W)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_req   (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_res  (out_res),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Local copy of the cache: key store, fill count and size register.
    logic [KEY_W-1:0]  key_mem [CAPACITY];
    int unsigned       held_count = 0;
    logic [SIZE_W-1:0] size_reg   = SIZE_RESET;

    t_res             outcome_fifo [$];
    logic [KEY_W-1:0] key_pool [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int holds_asked        = 0;
    int holds_done         = 0;
    int hold_left          = 0;
    int idle_cycles        = 0;

    int mismatches     = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int hit_count      = 0;
    int evict_count    = 0;
    int bad_vict_count = 0;
    int size_writes    = 0;

    // Size 0 behaves as 1, anything above the capacity as the capacity.
    function automatic int unsigned effective_size();
        int unsigned eff;
        eff = 32'(size_reg);
        if (eff == 0) eff = 1;
        if (eff > CAPACITY) eff = CAPACITY;
        return eff;
    endfunction

    // Apply one request to the local cache and return the outcome it must give.
    // All held slots are searched, even those above a lowered size.
    function automatic t_res lookup_and_fill(t_req r);
        t_res        o;
        int unsigned eff;
        int unsigned slot;
        eff  = effective_size();
        slot = 32'(r.victim_slot);
        o    = '0;
        for (int i = 0; i < held_count; i++) begin
            if (key_mem[i] == r.access_key) begin
                o.hit = 1'b1;
                hit_count++;
                return o;
            end
        end
        if (held_count < eff) begin
            key_mem[held_count] = r.access_key;
            held_count++;
            return o;
        end
        // Full: evict among slots below the effective size, slot 0 if out of range.
        if (slot >= eff) begin
            slot         = 0;
            o.bad_victim = 1'b1;
            bad_vict_count++;
        end
        o.evicted     = 1'b1;
        o.evicted_key = key_mem[slot];
        key_mem[slot] = r.access_key;
        evict_count++;
        return o;
    endfunction

    // Mix keys already stored with fresh ones so hits, fills and evictions all occur.
    function automatic void fill_pool();
        int n;
        n = int'(2 * effective_size() + 4);
        if (n > POOL_MAX) n = POOL_MAX;
        key_pool.delete();
        repeat (n) begin
            if (held_count != 0 && $urandom_range(1) == 0)
                key_pool.push_back(key_mem[$urandom_range(held_count - 1)]);
            else
                key_pool.push_back({$urandom, $urandom});
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(99) < 75)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VICTIM_W-1:0] pick_victim();
        if ($urandom_range(1) == 0)
            return VICTIM_W'($urandom_range(effective_size() - 1));
        return VICTIM_W'($urandom_range(1023));
    endfunction

    // Offer one request, optionally after an idle gap, and predict its outcome
    // at the edge that accepts it. Valid stays high for the next request.
    task automatic send_access(input logic [KEY_W-1:0] key, input logic [VICTIM_W-1:0] victim);
        t_req r;
        r.access_key  = key;
        r.victim_slot = victim;
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        outcome_fifo.push_back(lookup_and_fill(r));
        requests_sent++;
    endtask

    // Drop valid and hold until every predicted outcome has been returned.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outcome_fifo.size() != 0);
    endtask

    // Write cache_size only with nothing in flight.
    task automatic write_cache_size(input logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        size_reg = value;
        size_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [KEY_W-1:0] want,
                                 input logic [KEY_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Extremes of the key, repeated keys for hits, at the reset size.
    task automatic test_directed_fill();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_access(64'h0000_0000_0000_0000, 10'd0);
        send_access(64'hFFFF_FFFF_FFFF_FFFF, 10'd1023);
        send_access(64'h0000_0000_0000_0000, 10'd5);
        send_access(64'h8000_0000_0000_0000, 10'd0);
        send_access(64'hFFFF_FFFF_FFFF_FFFF, 10'd512);
        send_access(64'h5555_5555_5555_5555, 10'd341);
        send_access(64'hAAAA_AAAA_AAAA_AAAA, 10'd682);
        send_access(64'h8000_0000_0000_0000, 10'd1);
    endtask

    // Lower the size below the fill count: zero acts as one, out-of-range victims
    // fall back to slot 0, upper slots are still searched. Then go above capacity.
    task automatic test_shrink_below_held();
        write_cache_size(11'd0);
        send_access(64'h0000_0000_0000_0001, 10'd0);
        send_access(64'h0000_0000_0000_0002, 10'd1);
        send_access(64'h0000_0000_0000_0003, 10'd1023);
        send_access(64'hAAAA_AAAA_AAAA_AAAA, 10'd7);
        send_access(64'h0000_0000_0000_0003, 10'd0);
        write_cache_size(11'd1);
        send_access(64'h0000_0000_0000_0004, 10'd0);
        send_access(64'h0000_0000_0000_0000, 10'd512);
        write_cache_size(11'd2047);
        send_access(64'h0000_0000_0000_0006, 10'd3);
        send_access(64'h0000_0000_0000_0007, 10'd1023);
        send_access(64'h0000_0000_0000_0006, 10'd0);
    endtask

    // Hold off the receiver for a long stretch while requests keep coming, so the
    // core backs up and stalls its input.
    task automatic test_back_pressure();
        write_cache_size(11'd4);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        fill_pool();
        holds_asked++;
        repeat (40) send_access(pick_key(), pick_victim());
    endtask

    // Pause the sender until everything has come back, then resume.
    task automatic test_pause_and_resume();
        write_cache_size(11'd12);
        sender_idle_pct    = 35;
        receiver_stall_pct = 0;
        fill_pool();
        repeat (25) send_access(pick_key(), pick_victim());
        wait_drained();
        repeat (25) send_access(pick_key(), pick_victim());
    endtask

    task automatic test_random_traffic(input logic [SIZE_W-1:0] size, input int count,
                                       input int send_pct, input int stall_pct);
        write_cache_size(size);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        fill_pool();
        repeat (count) send_access(pick_key(), pick_victim());
    endtask

    // Receiver: random stalls, or a counted hold-off when one is asked for.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (holds_done != holds_asked) begin
            out_stall <= 1'b1;
            hold_left = HOLD_CYCLES - 1;
            holds_done++;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Compare each accepted result with the oldest predicted outcome.
    always @(posedge clk) begin : result_check
        t_res want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (outcome_fifo.size() == 0) begin
                note_mismatch("result with no request waiting", '0, out_res.evicted_key);
            end else begin
                want = outcome_fifo.pop_front();
                if (out_res.hit !== want.hit)
                    note_mismatch("hit", KEY_W'(want.hit), KEY_W'(out_res.hit));
                if (out_res.evicted !== want.evicted)
                    note_mismatch("evicted", KEY_W'(want.evicted), KEY_W'(out_res.evicted));
                if (out_res.evicted_key !== want.evicted_key)
                    note_mismatch("evicted_key", want.evicted_key, out_res.evicted_key);
                if (out_res.bad_victim !== want.bad_victim)
                    note_mismatch("bad_victim", KEY_W'(want.bad_victim),
                                  KEY_W'(out_res.bad_victim));
            end
        end
    end

    // Abort when no handshake of any kind has happened for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request, result or write for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_fill();
        test_shrink_below_held();
        test_back_pressure();
        test_pause_and_resume();
        test_random_traffic(11'd2, 60, 0, 0);
        test_random_traffic(11'd8, 70, 83, 0);
        test_random_traffic(11'd16, 70, 0, 83);
        test_random_traffic(11'($urandom_range(40, 3)), 70, 35, 35);
        test_random_traffic(11'd64, 70, 0, 0);
        test_random_traffic(11'd2047, 20, 0, 83);
        test_random_traffic(11'd1024, 20, 35, 35);
        // Shrink again well below the fill count.
        test_random_traffic(11'($urandom_range(24, 1)), 80, 83, 0);

        wait_drained();
        repeat (END_TAIL) @(posedge clk);

        $display("%0d requests, %0d results: %0d hits, %0d evictions (%0d out-of-range victims)",
                 requests_sent, results_seen, hit_count, evict_count, bad_vict_count);
        $display("%0d cache_size writes, %0d slots filled, %0d mismatches",
                 size_writes, held_count, mismatches);
        if (mismatches == 0 && outcome_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* random_replacement_cache_core.f */
sv/rrc_pkg.sv
sv/rrc_ctrl.sv
sv/rrc_dpath.sv
sv/random_replacement_cache_core.sv
dv/random_replacement_cache_core_tb.sv
